[rtl/assert_macros.svh]
// assert_macros.svh: assertion macros used by the checker file.
// Depends on nothing; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while out of reset.
`define RSSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked during reset.
`define RSSP_ASSERT_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rssp_pkg.sv]
// rssp_pkg: types, constants and helpers of the ramp/soak setpoint profiler.
// Used by the controller, the datapath, the top level and the checker.
package rssp_pkg;

  localparam int MAX_STAGES_DEF = 16;
  localparam int STAGE_W    = 5;
  localparam int TEMP_W     = 16;
  localparam int RATE_W     = 15;
  localparam int MIN_W      = 15;
  localparam int ES_W       = 32;
  localparam int MC_W       = 16;
  localparam int CC_W       = 8;
  localparam int MARGIN_W   = 15;
  localparam int UNIT_W     = 10;
  localparam int PROD_W     = RATE_W + ES_W;
  localparam int DIV_W      = 20;
  localparam int VAL_W      = PROD_W + 2;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int SEC_PER_MIN = 60;
  localparam int DECI_FACTOR = 10;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_WRITE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STAGE_COUNT  = 3'd0,
    REG_MARGIN       = 3'd1,
    REG_CONFIRM      = 3'd2,
    REG_UNIT_DIV     = 3'd3,
    REG_NO_DECIMALS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_PRV,
    ST_MUL,
    ST_DIV,
    ST_VAL,
    ST_FIN
  } state_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [TEMP_W-1:0] measured_value;
    logic [STAGE_W-1:0]       stage_index;
    logic signed [TEMP_W-1:0] stage_temperature;
    logic [RATE_W-1:0]        stage_rate;
    logic [MIN_W-1:0]         stage_minutes;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] setpoint;
    logic                     setpoint_written;
    logic                     running;
    logic                     soaking;
    logic [STAGE_W-1:0]       current_stage;
    logic [MC_W-1:0]          elapsed_minutes;
  } out_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [RATE_W-1:0]        rate;
    logic [MIN_W-1:0]         mins;
  } stage_entry_t;

  typedef struct packed {
    logic latch_in;
    logic rd_cur;
    logic rd_prv;
    logic cap_prv;
    logic mul;
    logic div_step;
    logic val;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic can_commit;
  } ctrl_sts_t;

  function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] lo;
    hi = VAL_W'(32767);
    lo = -VAL_W'(32768);
    if (v > hi) return 16'sh7FFF;
    else if (v < lo) return 16'sh8000;
    else return v[TEMP_W-1:0];
  endfunction

endpackage

[rtl/ramp_soak_setpoint_profiler_top.sv]
// ramp_soak_setpoint_profiler_top: top level of the ramp/soak setpoint profiler.
// Instantiates rssp_ctrl and rssp_dp; types from rssp_pkg.
//
// Usage:
//   in_*   : one item per event (one-second tick, start key, advance key,
//            stage-table write), valid/ready handshake.
//   out_*  : exactly one result item per input item, in order; it carries
//            the setpoint (0 unless setpoint_written) and the state after
//            the step.
//   cfg_*  : register writes (index 0..4), always ready; write only while
//            the block is idle. Indexes 5..7 are dropped.
// Sequencing:
//   A tick passes through two stage-table reads on the single read port,
//   one multiply, the one-bit-per-cycle restoring divider, one add or
//   subtract and the commit. Start, advance and write items go from idle
//   straight to the commit state. One item is in work at a time; the next
//   is accepted once the previous one has committed.
// Reset: synchronous on rst_n low; profile stopped at stage 1, counters
//   cleared, config at defaults. The stage table is not cleared: entries
//   read before they are written hold unknown values.
// Stall: a result waits in the output register; the block completes the
//   next item's work and holds it at commit until the register frees.
module ramp_soak_setpoint_profiler_top #(
  parameter int MAX_STAGES = rssp_pkg::MAX_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rssp_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rssp_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rssp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rssp_pkg::ctrl_cmd_t cmd;
  rssp_pkg::ctrl_sts_t sts;

  // config writes never stall
  assign cfg_ready = 1'b1;

  rssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rssp_dp #(
    .MAX_STAGES (MAX_STAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[rtl/rssp_ctrl.sv]
// rssp_ctrl: sequencer of the profiler; reads the stage table, runs the
// divider and commits each item. Depends on rssp_pkg.
module rssp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rssp_pkg::ctrl_sts_t  sts,
  output rssp_pkg::ctrl_cmd_t  cmd
);

  rssp_pkg::state_t state_r, state_nxt;
  logic [rssp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rssp_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      rssp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sts.in_is_tick ? rssp_pkg::ST_RD_CUR : rssp_pkg::ST_FIN;
      end
      rssp_pkg::ST_RD_CUR: state_nxt = rssp_pkg::ST_RD_PRV;
      rssp_pkg::ST_RD_PRV: state_nxt = rssp_pkg::ST_MUL;
      rssp_pkg::ST_MUL: begin
        state_nxt = rssp_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      rssp_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rssp_pkg::CNT_W'(rssp_pkg::PROD_W - 1)) state_nxt = rssp_pkg::ST_VAL;
      end
      rssp_pkg::ST_VAL: state_nxt = rssp_pkg::ST_FIN;
      rssp_pkg::ST_FIN: begin
        if (sts.can_commit) state_nxt = rssp_pkg::ST_IDLE;
      end
      default: state_nxt = rssp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = (state_r == rssp_pkg::ST_IDLE);
    cmd.latch_in = (state_r == rssp_pkg::ST_IDLE) && in_valid;
    cmd.rd_cur   = (state_r == rssp_pkg::ST_RD_CUR);
    cmd.rd_prv   = (state_r == rssp_pkg::ST_RD_PRV);
    cmd.cap_prv  = (state_r == rssp_pkg::ST_MUL);
    cmd.mul      = (state_r == rssp_pkg::ST_MUL);
    cmd.div_step = (state_r == rssp_pkg::ST_DIV);
    cmd.val      = (state_r == rssp_pkg::ST_VAL);
    cmd.commit   = (state_r == rssp_pkg::ST_FIN) && sts.can_commit;
  end

endmodule

[rtl/rssp_dp.sv]
// rssp_dp: datapath of the profiler; stage table, profile state, config
// registers, multiplier, radix-2 divider and output register. Uses rssp_pkg.
module rssp_dp #(
  parameter int MAX_STAGES = rssp_pkg::MAX_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rssp_pkg::in_item_t                  in_data,
  output rssp_pkg::out_item_t                 out_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                cfg_valid,
  input  logic [rssp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rssp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rssp_pkg::ctrl_cmd_t                 cmd,
  output rssp_pkg::ctrl_sts_t                 sts
);

  localparam int AW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int SW = $clog2(MAX_STAGES + 1);
  localparam int VW = rssp_pkg::VAL_W;
  localparam int PW = rssp_pkg::PROD_W;
  localparam int DW = rssp_pkg::DIV_W;

  // config registers
  logic [rssp_pkg::STAGE_W-1:0]  sc_r;
  logic [rssp_pkg::MARGIN_W-1:0] margin_r;
  logic [rssp_pkg::CC_W-1:0]     confirm_r;
  logic [rssp_pkg::UNIT_W-1:0]   unit_r;
  logic                          nodec_r;

  // profile state
  logic                        run_r, run_nxt;
  logic                        phase_r, phase_nxt;
  logic [SW-1:0]               stage_r, stage_nxt;
  logic [rssp_pkg::MC_W-1:0]   mc_r, mc_nxt;
  logic [rssp_pkg::ES_W-1:0]   es_r, es_nxt;
  logic [rssp_pkg::CC_W-1:0]   cc_r, cc_nxt;

  // working registers
  rssp_pkg::in_item_t            item_r;
  rssp_pkg::stage_entry_t        stage_mem [MAX_STAGES];
  rssp_pkg::stage_entry_t        mem_q_r;
  rssp_pkg::stage_entry_t        cur_r;
  logic signed [rssp_pkg::TEMP_W-1:0] prv_r;
  logic [PW-1:0]                 dq_r;
  logic [DW-1:0]                 rem_r;
  logic [DW-1:0]                 dvs_r;
  logic signed [VW-1:0]          v_r;
  logic                          out_valid_r;
  rssp_pkg::out_item_t           out_r;

  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [rssp_pkg::ES_W-1:0]     es1;
  logic [rssp_pkg::UNIT_W-1:0]   unit_eff;
  logic [DW:0]                   trial;
  logic                          q_bit;
  logic signed [VW-1:0]          prv_x, tgt_x, q_x, lim_x, v_c;
  logic                          up, eq, reached;
  logic [rssp_pkg::CC_W-1:0]     cc1;
  logic [SW-1:0]                 eff;
  logic                          soak_done, idx_ok;
  logic signed [rssp_pkg::TEMP_W-1:0] sp;
  logic                          wr;

  assign sts.in_is_tick = (in_data.operation == rssp_pkg::OP_TICK);
  assign sts.can_commit = !out_valid_r || out_ready;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r      <= rssp_pkg::STAGE_W'(1);
      margin_r  <= '0;
      confirm_r <= rssp_pkg::CC_W'(3);
      unit_r    <= rssp_pkg::UNIT_W'(1);
      nodec_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rssp_pkg::REG_STAGE_COUNT: sc_r      <= cfg_data[rssp_pkg::STAGE_W-1:0];
        rssp_pkg::REG_MARGIN:      margin_r  <= cfg_data[rssp_pkg::MARGIN_W-1:0];
        rssp_pkg::REG_CONFIRM:     confirm_r <= cfg_data[rssp_pkg::CC_W-1:0];
        rssp_pkg::REG_UNIT_DIV:    unit_r    <= cfg_data[rssp_pkg::UNIT_W-1:0];
        rssp_pkg::REG_NO_DECIMALS: nodec_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage table: one write port, one registered read port
  assign idx_ok  = (item_r.stage_index >= rssp_pkg::STAGE_W'(1)) &&
                   (32'(item_r.stage_index) <= MAX_STAGES);
  assign wr_en   = cmd.commit && (item_r.operation == rssp_pkg::OP_WRITE) && idx_ok;
  assign wr_addr = AW'(item_r.stage_index - rssp_pkg::STAGE_W'(1));
  assign rd_en   = cmd.rd_cur || cmd.rd_prv;
  assign rd_addr = cmd.rd_cur ? AW'(stage_r - SW'(1)) : AW'(stage_r - SW'(2));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stage_mem[wr_addr] <= '{temp: item_r.stage_temperature,
                              rate: item_r.stage_rate,
                              mins: item_r.stage_minutes};
    end
    if (rd_en) mem_q_r <= stage_mem[rd_addr];
  end

  // operand capture, multiply, divide
  assign es1      = es_r + 1'b1;
  assign unit_eff = (unit_r == '0) ? rssp_pkg::UNIT_W'(1) : unit_r;
  assign trial    = {rem_r, dq_r[PW-1]};
  assign q_bit    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_data;
    if (cmd.rd_prv)   cur_r  <= mem_q_r;
    if (cmd.cap_prv)  prv_r  <= (stage_r == SW'(1)) ? '0 : mem_q_r.temp;
    if (cmd.mul) begin
      dq_r  <= PW'(cur_r.rate) * PW'(es1);
      rem_r <= '0;
      dvs_r <= DW'(unit_eff) * DW'(nodec_r ? rssp_pkg::SEC_PER_MIN * rssp_pkg::DECI_FACTOR
                                           : rssp_pkg::SEC_PER_MIN);
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
      dq_r  <= {dq_r[PW-2:0], q_bit};
    end
    if (cmd.val) v_r <= up ? prv_x + q_x : prv_x - q_x;
  end

  // step logic
  assign prv_x = VW'(prv_r);
  assign tgt_x = VW'(cur_r.temp);
  assign q_x   = $signed({2'b00, dq_r});
  assign up    = tgt_x > prv_x;
  assign eq    = tgt_x == prv_x;
  assign reached = up ? (item_r.measured_value >= cur_r.temp)
                      : (item_r.measured_value <= cur_r.temp);
  assign cc1   = cc_r + 1'b1;
  assign lim_x = up ? tgt_x + VW'($signed({1'b0, margin_r}))
                    : tgt_x - VW'($signed({1'b0, margin_r}));
  assign soak_done = rssp_pkg::ES_W'(cur_r.mins * 21'd60) <= es1;
  assign eff = (sc_r == '0) ? SW'(1) :
               (32'(sc_r) > MAX_STAGES) ? SW'(MAX_STAGES) : SW'(sc_r);

  always_comb begin
    run_nxt   = run_r;
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    mc_nxt    = mc_r;
    es_nxt    = es_r;
    cc_nxt    = cc_r;
    sp        = '0;
    wr        = 1'b0;
    v_c       = v_r;
    case (item_r.operation)
      rssp_pkg::OP_TICK: begin
        wr = 1'b1;
        if (!run_r) begin
          es_nxt    = '0;
          cc_nxt    = '0;
          mc_nxt    = '0;
          phase_nxt = 1'b0;
        end else begin
          es_nxt = es1;
          if (mc_r != '0 && es1 > rssp_pkg::ES_W'({6'b0, mc_r} * 22'd60))
            mc_nxt = mc_r + 1'b1;
          if (!phase_r) begin
            if (eq) begin
              cc_nxt    = '0;
              es_nxt    = '0;
              phase_nxt = 1'b1;
              sp        = cur_r.temp;
            end else if (reached) begin
              if (cc1 != confirm_r) begin
                cc_nxt = cc1;
                sp     = rssp_pkg::sat16(v_r);
              end else begin
                cc_nxt    = '0;
                es_nxt    = '0;
                phase_nxt = 1'b1;
                sp        = cur_r.temp;
              end
            end else begin
              // hold the ramp within the margin past the target
              if (up && v_r >= lim_x) v_c = lim_x;
              if (!up && v_r <= lim_x) v_c = lim_x;
              sp = rssp_pkg::sat16(v_c);
            end
          end else begin
            wr = 1'b0;
            if (soak_done) begin
              es_nxt = '0;
              mc_nxt = rssp_pkg::MC_W'(1);
              if (stage_r < eff) begin
                stage_nxt = stage_r + 1'b1;
                phase_nxt = 1'b0;
              end else begin
                // last stage done: stop and issue its target
                wr        = 1'b1;
                sp        = cur_r.temp;
                run_nxt   = 1'b0;
                stage_nxt = SW'(1);
              end
            end
          end
        end
      end
      rssp_pkg::OP_START: begin
        run_nxt   = 1'b1;
        stage_nxt = SW'(1);
      end
      rssp_pkg::OP_ADVANCE: begin
        if (stage_r < eff) begin
          stage_nxt = stage_r + 1'b1;
          phase_nxt = 1'b0;
        end else begin
          run_nxt   = 1'b0;
          stage_nxt = SW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      phase_r     <= 1'b0;
      stage_r     <= SW'(1);
      mc_r        <= '0;
      es_r        <= '0;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        run_r   <= run_nxt;
        phase_r <= phase_nxt;
        stage_r <= stage_nxt;
        mc_r    <= mc_nxt;
        es_r    <= es_nxt;
        cc_r    <= cc_nxt;
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.setpoint         <= wr ? sp : '0;
      out_r.setpoint_written <= wr;
      out_r.running          <= run_nxt;
      out_r.soaking          <= phase_nxt;
      out_r.current_stage    <= rssp_pkg::STAGE_W'(stage_nxt);
      out_r.elapsed_minutes  <= mc_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/rssp_checker.sv]
// rssp_checker: port-level assertions for the profiler top, bound below.
// Depends on rssp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rssp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input rssp_pkg::out_item_t              out_data
);

  `RSSP_ASSERT_NXT(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")
  `RSSP_ASSERT_IMP(a_busy_after_accept, clk, rst_n, in_valid && in_ready, ##1 !in_ready, "item accepted while busy")
  `RSSP_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 (out_valid && $stable(out_data)), "stalled result changed")

endmodule

bind ramp_soak_setpoint_profiler_top rssp_checker u_rssp_checker (.*);
